/* src/id3tfe_pkg.sv */
// ----------------------------------------------------------------------------
// id3tfe_pkg
// Shared types and constants of the ID3v2.4 text frame extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package id3tfe_pkg;

    localparam int unsigned WIN_LEN = 8;

    // Field index of the comment frame (five bytes skipped after its header)
    localparam logic [2:0] FIELD_COMM = 3'd5;

    // Eight-byte look-behind window, entry 0 is the oldest byte
    typedef logic [WIN_LEN-1:0][7:0] t_window;

    // Result of the window compare
    typedef struct packed {
        logic        hit;
        logic [2:0]  field;
        logic [28:0] length;   // content length after the encoding/skip bytes
    } t_match;

    function automatic logic [31:0] frame_tag(input logic [2:0] f);
        logic [31:0] id;
        unique case (f)
            3'd0:    id = "TIT2";
            3'd1:    id = "TPE1";
            3'd2:    id = "TALB";
            3'd3:    id = "TRCK";
            3'd4:    id = "TDRC";
            3'd5:    id = "COMM";
            3'd6:    id = "TCON";
            default: id = 32'h0;
        endcase
        return id;
    endfunction

endpackage

`default_nettype wire

/* src/id3tfe_if.sv */
// ----------------------------------------------------------------------------
// id3tfe_if
// Valid/ready channels for file bytes in and extracted results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface id3tfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output first_byte,
                    output final_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte,
                    input final_byte, output ready);
endinterface

interface id3tfe_out_if;
    logic       valid;
    logic       ready;
    logic       has_content;
    logic [2:0] field_index;
    logic [7:0] content_byte;
    logic       field_end;
    logic       has_status;
    logic [1:0] status;

    modport source (output valid, output has_content, output field_index,
                    output content_byte, output field_end, output has_status,
                    output status, input ready);
    modport sink   (input valid, input has_content, input field_index,
                    input content_byte, input field_end, input has_status,
                    input status, output ready);
endinterface

`default_nettype wire

/* src/id3tfe_match.sv */
// ----------------------------------------------------------------------------
// id3tfe_match
// Compares the look-behind window against the frame IDs and decodes the
// frame size into the remaining content length.
// ----------------------------------------------------------------------------
`default_nettype none

module id3tfe_match #(
    parameter int unsigned FRAME_KINDS = 7
) (
    input  wire id3tfe_pkg::t_window i_window,
    output id3tfe_pkg::t_match       o_match
);

    logic [31:0] w_id;
    logic [28:0] w_size;
    logic [28:0] w_sub;

    assign w_id = {i_window[0], i_window[1], i_window[2], i_window[3]};

    // Size bytes are OR-ed in whole at 7-bit steps
    assign w_size = 29'(i_window[7])
                  | (29'(i_window[6]) << 7)
                  | (29'(i_window[5]) << 14)
                  | (29'(i_window[4]) << 21);

    always_comb begin
        o_match.hit   = 1'b0;
        o_match.field = 3'd0;
        for (int f = int'(FRAME_KINDS) - 1; f >= 0; f--) begin
            if (w_id == id3tfe_pkg::frame_tag(3'(f))) begin
                o_match.hit   = 1'b1;
                o_match.field = 3'(f);
            end
        end
        w_sub = (o_match.field == id3tfe_pkg::FIELD_COMM) ? 29'd5 : 29'd1;
        // Saturate a short frame to zero content bytes
        o_match.length = (w_size > w_sub) ? (w_size - w_sub) : 29'd0;
    end

endmodule

`default_nettype wire

/* src/id3tfe_unit.sv */
// ----------------------------------------------------------------------------
// id3v24_text_frame_extractor_unit
// Parses the ID3v2.4 header and streams the content bytes of the title,
// artist, album, track, year, comment and genre frames.
// ----------------------------------------------------------------------------
// Each accepted byte's result is written to the output register.
// Throughput: one byte per cycle while the sink keeps up; the parse state updates in the accept cycle.
// A byte is taken while a result waits as long as the sink takes it that cycle.
// Reset (i_rst_n low, synchronous) returns to idle and empties the output;
// until a byte with first_byte set arrives, bytes are consumed without result.
// ----------------------------------------------------------------------------
`default_nettype none

module id3v24_text_frame_extractor_unit #(
    parameter int unsigned FRAME_KINDS = 7
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    id3tfe_in_if.sink       i_in,
    id3tfe_out_if.source    o_out
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_HEADER  = 3'd1;
    localparam logic [2:0] PH_SCAN    = 3'd2;
    localparam logic [2:0] PH_SKIP    = 3'd3;
    localparam logic [2:0] PH_CONTENT = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;

    localparam logic [1:0] ST_PARSED  = 2'd0;
    localparam logic [1:0] ST_NOT_ID3 = 2'd1;
    localparam logic [1:0] ST_BAD_VER = 2'd2;

    localparam logic [3:0] HDR_LAST   = 4'd9;
    localparam logic [3:0] WIN_FULL   = 4'd8;
    localparam logic [7:0] VERSION    = 8'h04;

    // Parse state
    logic [2:0]              r_phase,     n_phase;
    logic [3:0]              r_hdr_cnt,   n_hdr_cnt;
    logic [28:0]             r_tag_size,  n_tag_size;
    logic [29:0]             r_body_pos,  n_body_pos;
    id3tfe_pkg::t_window     r_win,       n_win;
    logic [3:0]              r_win_fill,  n_win_fill;
    logic [2:0]              r_frames,    n_frames;
    logic [2:0]              r_field,     n_field;
    logic [2:0]              r_skip,      n_skip;
    logic [28:0]             r_cont_rem,  n_cont_rem;

    // Result register
    logic       r_o_valid;
    logic       r_o_has_c;
    logic [2:0] r_o_field;
    logic [7:0] r_o_byte;
    logic       r_o_fend;
    logic       r_o_has_s;
    logic [1:0] r_o_status;

    logic                w_accept;
    id3tfe_pkg::t_window w_shift;
    id3tfe_pkg::t_match  w_match;

    logic       c_has_c;
    logic       c_has_s;
    logic       c_fend;
    logic [1:0] c_status;
    logic       c_done;
    logic       c_end_body;
    logic [7:0] c_magic;

    assign i_in.ready = !r_o_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    // Window after shifting in the current byte
    always_comb begin
        for (int i = 0; i < int'(id3tfe_pkg::WIN_LEN) - 1; i++) begin
            w_shift[i] = r_win[i+1];
        end
        w_shift[id3tfe_pkg::WIN_LEN-1] = i_in.data_byte;
    end

    id3tfe_match #(
        .FRAME_KINDS (FRAME_KINDS)
    ) u_match (
        .i_window (w_shift),
        .o_match  (w_match)
    );

    always_comb begin
        n_phase    = r_phase;
        n_hdr_cnt  = r_hdr_cnt;
        n_tag_size = r_tag_size;
        n_body_pos = r_body_pos;
        n_win      = r_win;
        n_win_fill = r_win_fill;
        n_frames   = r_frames;
        n_field    = r_field;
        n_skip     = r_skip;
        n_cont_rem = r_cont_rem;
        c_has_c    = 1'b0;
        c_has_s    = 1'b0;
        c_fend     = 1'b0;
        c_status   = ST_PARSED;
        c_done     = 1'b0;
        c_end_body = 1'b0;
        c_magic    = 8'h00;

        if (i_in.first_byte) begin
            n_phase    = PH_HEADER;
            n_hdr_cnt  = 4'd0;
            n_tag_size = 29'd0;
            n_body_pos = 30'd0;
            n_win_fill = 4'd0;
            n_frames   = 3'd0;
            n_field    = 3'd0;
            n_skip     = 3'd0;
            n_cont_rem = 29'd0;
        end

        unique case (n_hdr_cnt[1:0])
            2'd0:    c_magic = "I";
            2'd1:    c_magic = "D";
            2'd2:    c_magic = "3";
            default: c_magic = 8'h00;
        endcase

        if (n_phase == PH_HEADER) begin
            if (n_hdr_cnt < 4'd3 && i_in.data_byte != c_magic) begin
                c_has_s  = 1'b1;
                c_status = ST_NOT_ID3;
            end else if (n_hdr_cnt == 4'd3 && i_in.data_byte != VERSION) begin
                c_has_s  = 1'b1;
                c_status = ST_BAD_VER;
            end else begin
                unique case (n_hdr_cnt)
                    4'd6:    n_tag_size[28:21] = n_tag_size[28:21] | i_in.data_byte;
                    4'd7:    n_tag_size[21:14] = n_tag_size[21:14] | i_in.data_byte;
                    4'd8:    n_tag_size[14:7]  = n_tag_size[14:7]  | i_in.data_byte;
                    4'd9:    n_tag_size[7:0]   = n_tag_size[7:0]   | i_in.data_byte;
                    default: n_tag_size = n_tag_size;
                endcase
                if (n_hdr_cnt == HDR_LAST) begin
                    if (n_tag_size == 29'd0 || i_in.final_byte) begin
                        c_has_s  = 1'b1;
                        c_status = ST_PARSED;
                    end else begin
                        n_phase    = PH_SCAN;
                        n_win_fill = 4'd0;
                        n_body_pos = 30'd0;
                    end
                end else if (i_in.final_byte) begin
                    c_has_s  = 1'b1;
                    c_status = ST_NOT_ID3;
                end
                n_hdr_cnt = n_hdr_cnt + 4'd1;
            end
        end else if (n_phase == PH_SCAN || n_phase == PH_SKIP ||
                     n_phase == PH_CONTENT) begin
            n_body_pos = n_body_pos + 30'd1;
            c_end_body = (n_body_pos >= {1'b0, n_tag_size}) || i_in.final_byte;

            priority case (n_phase)
                PH_SCAN: begin
                    n_win = w_shift;
                    if (n_win_fill < WIN_FULL) begin
                        n_win_fill = n_win_fill + 4'd1;
                    end
                    if (n_win_fill >= WIN_FULL && w_match.hit) begin
                        n_frames   = n_frames + 3'd1;
                        n_field    = w_match.field;
                        n_cont_rem = w_match.length;
                        // rest of frame header (2) plus encoding or comment prefix
                        n_skip     = (w_match.field == id3tfe_pkg::FIELD_COMM) ?
                                     3'd7 : 3'd3;
                        n_phase    = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    n_skip = n_skip - 3'd1;
                    if (n_skip == 3'd0) begin
                        if (n_cont_rem == 29'd0) begin
                            if (n_frames >= 3'(FRAME_KINDS)) begin
                                c_done = 1'b1;
                            end else begin
                                n_phase    = PH_SCAN;
                                n_win_fill = 4'd0;
                            end
                        end else begin
                            n_phase = PH_CONTENT;
                        end
                    end
                end
                default: begin
                    c_has_c    = 1'b1;
                    n_cont_rem = n_cont_rem - 29'd1;
                    if (n_cont_rem == 29'd0) begin
                        c_fend = 1'b1;
                        if (n_frames >= 3'(FRAME_KINDS)) begin
                            c_done = 1'b1;
                        end else begin
                            n_phase    = PH_SCAN;
                            n_win_fill = 4'd0;
                        end
                    end
                    if (c_end_body) begin
                        c_fend = 1'b1;   // content cut off at the end of the body
                    end
                end
            endcase

            if (c_done || c_end_body) begin
                c_has_s  = 1'b1;
                c_status = ST_PARSED;
            end
        end

        if (c_has_s) begin
            n_phase = PH_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_hdr_cnt  <= 4'd0;
            r_tag_size <= 29'd0;
            r_body_pos <= 30'd0;
            r_win_fill <= 4'd0;
            r_frames   <= 3'd0;
            r_field    <= 3'd0;
            r_skip     <= 3'd0;
            r_cont_rem <= 29'd0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase    <= n_phase;
                r_hdr_cnt  <= n_hdr_cnt;
                r_tag_size <= n_tag_size;
                r_body_pos <= n_body_pos;
                r_win_fill <= n_win_fill;
                r_frames   <= n_frames;
                r_field    <= n_field;
                r_skip     <= n_skip;
                r_cont_rem <= n_cont_rem;
                r_o_valid  <= c_has_c || c_has_s;
            end else if (o_out.ready) begin
                r_o_valid  <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_win      <= n_win;
            r_o_has_c  <= c_has_c;
            r_o_field  <= c_has_c ? n_field : 3'd0;
            r_o_byte   <= c_has_c ? i_in.data_byte : 8'd0;
            r_o_fend   <= c_has_c && c_fend;
            r_o_has_s  <= c_has_s;
            r_o_status <= c_has_s ? c_status : ST_PARSED;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.has_content  = r_o_has_c;
    assign o_out.field_index  = r_o_field;
    assign o_out.content_byte = r_o_byte;
    assign o_out.field_end    = r_o_fend;
    assign o_out.has_status   = r_o_has_s;
    assign o_out.status       = r_o_status;

endmodule

`default_nettype wire
